// ===== hw/rtl/mdl_pkg.sv =====
// ----------------------------------------------------------------------------
// mdl_pkg
// Shared types and constants for the markdown token lexer.
// ----------------------------------------------------------------------------
`default_nettype none

package mdl_pkg;

	localparam int unsigned POS_WIDTH_DEF = 16;
	localparam int unsigned OUT_POS_W     = 16;
	localparam int unsigned Q_DEPTH       = 4;

	localparam logic [7:0] CH_HASH      = 8'h23;
	localparam logic [7:0] CH_STAR      = 8'h2A;
	localparam logic [7:0] CH_BRK_OPEN  = 8'h5B;
	localparam logic [7:0] CH_BRK_CLOSE = 8'h5D;
	localparam logic [7:0] CH_PAR_OPEN  = 8'h28;
	localparam logic [7:0] CH_PAR_CLOSE = 8'h29;
	localparam logic [7:0] CH_NEWLINE   = 8'h0A;
	localparam logic [7:0] CH_CHEVRON   = 8'h3E;
	localparam logic [7:0] CH_MINUS     = 8'h2D;
	localparam logic [7:0] CH_SPACE     = 8'h20;

	typedef enum logic [3:0] {
		KIND_TEXT,
		KIND_HASH,
		KIND_STAR,
		KIND_BRK_OPEN,
		KIND_BRK_CLOSE,
		KIND_PAR_OPEN,
		KIND_PAR_CLOSE,
		KIND_NEWLINE,
		KIND_CHEVRON,
		KIND_MINUS
	} kind_t;

	typedef struct packed {
		kind_t                  kind;
		logic [7:0]             char_out;
		logic                   starts_token;
		logic [OUT_POS_W-1:0]   token_line;
		logic [OUT_POS_W-1:0]   token_column;
		logic                   run_last;
	} result_t;

	// up to two results per transaction; r0 is always the first one
	typedef struct packed {
		logic [1:0] cnt;
		result_t    r0;
		result_t    r1;
	} push_t;

endpackage

`default_nettype wire

// ===== hw/rtl/mdl_in_if.sv =====
// ----------------------------------------------------------------------------
// mdl_in_if
// Byte input channel: valid/ready with one document byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdl_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] char_in;
	logic       end_of_input;

	modport source (output valid, output char_in, output end_of_input, input ready);
	modport sink   (input valid, input char_in, input end_of_input, output ready);
endinterface

`default_nettype wire

// ===== hw/rtl/mdl_out_if.sv =====
// ----------------------------------------------------------------------------
// mdl_out_if
// Token output channel: valid/ready with one classified byte per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdl_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  kind;
	logic [7:0]  char_out;
	logic        starts_token;
	logic [15:0] token_line;
	logic [15:0] token_column;
	logic        run_last;

	modport source (
		output valid, output kind, output char_out, output starts_token,
		output token_line, output token_column, output run_last, input ready
	);
	modport sink (
		input valid, input kind, input char_out, input starts_token,
		input token_line, input token_column, input run_last, output ready
	);
endinterface

`default_nettype wire

// ===== hw/rtl/mdl_core.sv =====
// ----------------------------------------------------------------------------
// mdl_core
// Input register, lookahead state and per-byte classification.
// ----------------------------------------------------------------------------
`default_nettype none

module mdl_core #(
	parameter int unsigned POS_WIDTH = mdl_pkg::POS_WIDTH_DEF
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	mdl_in_if.sink             din,
	input  wire logic          room,
	output mdl_pkg::push_t     push
);
	import mdl_pkg::*;

	typedef logic [POS_WIDTH-1:0] pos_t;

	typedef struct packed {
		logic    emit;
		result_t res;
		logic    topen;
		pos_t    tl;
		pos_t    tc;
	} rslv_t;

	localparam pos_t POS_ONE = pos_t'(1);
	localparam pos_t POS_MAX = '1;

	function automatic kind_t classify(input logic [7:0] c, input logic has_next,
	                                   input logic [7:0] nx);
		logic spaced;
		kind_t k;
		spaced = has_next && (nx == CH_SPACE || nx == c);
		case (c)
			CH_STAR:      k = KIND_STAR;
			CH_BRK_OPEN:  k = KIND_BRK_OPEN;
			CH_BRK_CLOSE: k = KIND_BRK_CLOSE;
			CH_PAR_OPEN:  k = KIND_PAR_OPEN;
			CH_PAR_CLOSE: k = KIND_PAR_CLOSE;
			CH_NEWLINE:   k = KIND_NEWLINE;
			CH_HASH:      k = spaced ? KIND_HASH : KIND_TEXT;
			CH_CHEVRON:   k = spaced ? KIND_CHEVRON : KIND_TEXT;
			CH_MINUS:     k = spaced ? KIND_MINUS : KIND_TEXT;
			default:      k = KIND_TEXT;
		endcase
		return k;
	endfunction

	function automatic rslv_t resolve(input logic [7:0] c, input pos_t line, input pos_t col,
	                                  input logic has_next, input logic [7:0] nx,
	                                  input logic topen, input pos_t tl, input pos_t tc);
		rslv_t r;
		kind_t k;
		r       = '0;
		r.topen = topen;
		r.tl    = tl;
		r.tc    = tc;
		k       = classify(c, has_next, nx);
		// a space outside a text run is dropped
		if (!(c == CH_SPACE && !topen)) begin
			r.emit             = 1'b1;
			r.res.kind         = k;
			r.res.char_out     = c;
			r.res.starts_token = 1'b1;
			r.res.token_line   = OUT_POS_W'(line);
			r.res.token_column = OUT_POS_W'(col);
			if (k != KIND_TEXT) begin
				r.topen = 1'b0;
			end else if (!topen) begin
				r.topen = 1'b1;
				r.tl    = line;
				r.tc    = col;
			end else begin
				r.res.starts_token = 1'b0;
				r.res.token_line   = OUT_POS_W'(tl);
				r.res.token_column = OUT_POS_W'(tc);
			end
		end
		return r;
	endfunction

	logic       valid_s1;
	logic [7:0] char_s1;
	logic       last_s1;

	logic [7:0] held_char_q;
	logic       held_valid_q;
	pos_t       held_line_q;
	pos_t       held_col_q;
	pos_t       line_q;
	pos_t       col_q;
	logic       text_open_q;
	pos_t       text_line_q;
	pos_t       text_col_q;

	logic  adv;
	rslv_t r_a;
	rslv_t r_b;
	logic  a_emit;
	logic  b_emit;
	logic  topen1;
	pos_t  tl1;
	pos_t  tc1;

	assign adv       = valid_s1 && room;
	assign din.ready = !valid_s1 || room;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			char_s1  <= '0;
			last_s1  <= 1'b0;
		end else if (din.ready) begin
			valid_s1 <= din.valid;
			char_s1  <= din.char_in;
			last_s1  <= din.end_of_input;
		end
	end

	always_comb begin
		r_a    = resolve(held_char_q, held_line_q, held_col_q, 1'b1, char_s1,
		                 text_open_q, text_line_q, text_col_q);
		a_emit = held_valid_q && r_a.emit;
		topen1 = held_valid_q ? r_a.topen : text_open_q;
		tl1    = held_valid_q ? r_a.tl : text_line_q;
		tc1    = held_valid_q ? r_a.tc : text_col_q;
		// final byte resolves with no successor
		r_b    = resolve(char_s1, line_q, col_q, 1'b0, 8'h00, topen1, tl1, tc1);
		b_emit = last_s1 && r_b.emit;

		push             = '0;
		push.cnt         = adv ? (2'(a_emit) + 2'(b_emit)) : 2'd0;
		push.r0          = a_emit ? r_a.res : r_b.res;
		push.r0.run_last = !(a_emit && b_emit);
		push.r1          = r_b.res;
		push.r1.run_last = 1'b1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_char_q  <= '0;
			held_valid_q <= 1'b0;
			held_line_q  <= POS_ONE;
			held_col_q   <= POS_ONE;
			line_q       <= POS_ONE;
			col_q        <= POS_ONE;
			text_open_q  <= 1'b0;
			text_line_q  <= POS_ONE;
			text_col_q   <= POS_ONE;
		end else if (adv) begin
			if (last_s1) begin
				held_char_q  <= '0;
				held_valid_q <= 1'b0;
				held_line_q  <= POS_ONE;
				held_col_q   <= POS_ONE;
				line_q       <= POS_ONE;
				col_q        <= POS_ONE;
				text_open_q  <= 1'b0;
				text_line_q  <= POS_ONE;
				text_col_q   <= POS_ONE;
			end else begin
				held_char_q  <= char_s1;
				held_valid_q <= 1'b1;
				held_line_q  <= line_q;
				held_col_q   <= col_q;
				text_open_q  <= topen1;
				text_line_q  <= tl1;
				text_col_q   <= tc1;
				if (char_s1 == CH_NEWLINE) begin
					col_q <= POS_ONE;
					if (line_q != POS_MAX) begin
						line_q <= line_q + POS_ONE;
					end
				end else if (col_q != POS_MAX) begin
					col_q <= col_q + POS_ONE;
				end
			end
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/mdl_outq.sv =====
// ----------------------------------------------------------------------------
// mdl_outq
// Small result queue: takes up to two results a cycle, drains one a cycle while dout.ready is high.
// ----------------------------------------------------------------------------
`default_nettype none

module mdl_outq (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  mdl_pkg::push_t     push,
	output logic               room,
	mdl_out_if.source          dout
);
	import mdl_pkg::*;

	localparam int unsigned QPW = $clog2(Q_DEPTH);
	localparam int unsigned QCW = $clog2(Q_DEPTH + 1);

	result_t          mem_q [Q_DEPTH];
	logic [QPW-1:0]   wr_q;
	logic [QPW-1:0]   rd_q;
	logic [QCW-1:0]   count_q;
	logic             pop;
	result_t          head;

	assign pop  = dout.valid && dout.ready;
	assign room = count_q <= QCW'(Q_DEPTH - 2);
	assign head = mem_q[rd_q];

	assign dout.valid        = count_q != '0;
	assign dout.kind         = head.kind;
	assign dout.char_out     = head.char_out;
	assign dout.starts_token = head.starts_token;
	assign dout.token_line   = head.token_line;
	assign dout.token_column = head.token_column;
	assign dout.run_last     = head.run_last;

	always_ff @(posedge clk) begin
		if (push.cnt != 2'd0) begin
			mem_q[wr_q] <= push.r0;
		end
		if (push.cnt == 2'd2) begin
			mem_q[wr_q + QPW'(1)] <= push.r1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= wr_q + QPW'(push.cnt);
			rd_q    <= rd_q + QPW'(pop);
			count_q <= count_q + QCW'(push.cnt) - QCW'(pop);
		end
	end

endmodule

`default_nettype wire

// ===== hw/rtl/markdown_token_lexer.sv =====
// ----------------------------------------------------------------------------
// markdown_token_lexer
// Streams a markdown document byte by byte and tags each byte as token or text.
// ----------------------------------------------------------------------------
// channel | dir | payload                                          | per transaction
// din     | in  | char_in, end_of_input                            | one byte
// dout    | out | kind, char_out, starts_token, token_line,        | one emitted byte
//         |     | token_column, run_last                           |
//
// One byte accepted per cycle while din.ready is high; each result is written
// into the result queue and leaves from its head.
// A byte is classified when its successor arrives, so each byte yields 0 or 1
// result, the final byte up to 2; a four-entry result queue absorbs the pair.
// din.ready drops only while the queue has fewer than two free entries.
// Reset returns to the start-of-document state; so does every final byte.
// ----------------------------------------------------------------------------
`default_nettype none

module markdown_token_lexer #(
	parameter int unsigned POS_WIDTH = mdl_pkg::POS_WIDTH_DEF
) (
	input  wire logic clk,
	input  wire logic arst_n,
	mdl_in_if.sink    din,
	mdl_out_if.source dout
);
	import mdl_pkg::*;

	push_t push;
	logic  room;

	mdl_core #(.POS_WIDTH(POS_WIDTH)) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.din    (din),
		.room   (room),
		.push   (push)
	);

	mdl_outq u_outq (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.room   (room),
		.dout   (dout)
	);

endmodule

`default_nettype wire

// ===== hw/rtl/mdl_checker.sv =====
// ----------------------------------------------------------------------------
// mdl_checker
// Port-level checks for the markdown token lexer, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module mdl_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        in_ready,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [3:0]  out_kind,
	input wire logic        out_starts,
	input wire logic [15:0] out_line,
	input wire logic [15:0] out_column
);
	import mdl_pkg::*;

	logic        prev_text_q;
	logic [15:0] prev_line_q;
	logic [15:0] prev_col_q;
	logic        out_xfer;

	assign out_xfer = out_valid && out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_text_q <= 1'b0;
			prev_line_q <= '0;
			prev_col_q  <= '0;
		end else if (out_xfer) begin
			prev_text_q <= out_kind == KIND_TEXT;
			prev_line_q <= out_line;
			prev_col_q  <= out_column;
		end
	end

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_line))
		else $error("result changed while stalled");

	// continuation bytes follow a text byte
	a_cont_after_text: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !out_starts |-> prev_text_q && out_kind == KIND_TEXT)
		else $error("text continuation without open text run");

	// continuation bytes keep the run's start position
	a_cont_pos: assert property (@(posedge clk) disable iff (!arst_n)
		out_xfer && !out_starts |-> out_line == prev_line_q && out_column == prev_col_q)
		else $error("text run position changed mid-run");

	// input only stalls behind a backed-up output
	a_backpressure: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |-> out_valid)
		else $error("input stalled with empty output");

endmodule

bind markdown_token_lexer mdl_checker u_mdl_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.in_ready   (din.ready),
	.out_valid  (dout.valid),
	.out_ready  (dout.ready),
	.out_kind   (dout.kind),
	.out_starts (dout.starts_token),
	.out_line   (dout.token_line),
	.out_column (dout.token_column)
);

`default_nettype wire
